// ===== rtl/core/rff_pkg.sv =====
package rff_pkg;

    localparam logic [7:0]  PREAMBLE      = 8'hD3;
    localparam logic [23:0] CRC24Q_POLY   = 24'h864CFB;  // 0x1864CFB without the x^24 term
    localparam logic [8:0]  MAX_PL_RESET  = 9'd300;
    localparam logic [5:0]  LAST_RESULT   = 6'd63;       // 64 results per byte at most

    localparam logic [1:0]  KIND_WAIT  = 2'd0;
    localparam logic [1:0]  KIND_FRAME = 2'd1;
    localparam logic [1:0]  KIND_DROP  = 2'd2;

    // one queued input word between front and back
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } q_word_t;

    // CRC-24Q over one byte, MSB first
    function automatic logic [23:0] crc24q_step(input logic [23:0] crc, input logic [7:0] d);
        logic [23:0] c;
        c = crc ^ {d, 16'h0000};
        for (int b = 0; b < 8; b++)
        begin
            if (c[23])
                c = {c[22:0], 1'b0} ^ CRC24Q_POLY;
            else
                c = {c[22:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/rff_in_queue.sv =====
module rff_in_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    output rff_pkg::q_word_t head,
    input  logic             pop
);
    import rff_pkg::*;

    // two-entry FIFO
    logic [7:0] data_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push, do_pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (cnt_reg != 2'd0);

    assign head.valid = (cnt_reg != 2'd0);
    assign head.data  = data_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, do_pop};
        rd_next  = do_pop ? ~rd_reg : rd_reg;
        wr_next  = push ? ~wr_reg : wr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg[wr_reg] <= rx_byte;
    end

endmodule

// ===== rtl/core/rff_engine.sv =====
module rff_engine #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rff_pkg::q_word_t q_head,
    output logic             q_pop,
    input  logic [8:0]       max_pl,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       event_kind,
    output logic [9:0]       frame_length,
    output logic [11:0]      message_id,
    output logic [9:0]       drop_count,
    output logic             is_last
);
    import rff_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int XW = 12;
    localparam logic [XW-1:0] DEPTH_X = XW'(BUFFER_DEPTH);

    typedef enum logic [10:0] {
        S_POP   = 11'b00000000001,
        S_CHECK = 11'b00000000010,
        S_B0    = 11'b00000000100,
        S_B1    = 11'b00000001000,
        S_B2    = 11'b00000010000,
        S_CRC   = 11'b00000100000,
        S_T0    = 11'b00001000000,
        S_T1    = 11'b00010000000,
        S_T2    = 11'b00100000000,
        S_SRCH  = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  rdoff_reg, rdoff_next;
    logic [9:0]     len_reg, len_next;
    logic [1:0]     b1_reg, b1_next;
    logic [23:0]    crc_reg, crc_next;
    logic [7:0]     rx0_reg, rx0_next, rx1_reg, rx1_next;
    logic [7:0]     id_hi_reg, id_lo_reg;
    logic [5:0]     cnt_reg, cnt_next;
    logic [1:0]     pkind_reg, pkind_next;
    logic [9:0]     pflen_reg, pflen_next;
    logic [CW-1:0]  pdrop_reg, pdrop_next;
    logic           ov_reg, ov_next;
    logic [1:0]     okind_reg, okind_next;
    logic [9:0]     oflen_reg, oflen_next;
    logic [11:0]    oid_reg, oid_next;
    logic [9:0]     odrop_reg, odrop_next;
    logic           olast_reg, olast_next;

    logic [7:0]     mem [BUFFER_DEPTH];
    logic [7:0]     rdata_reg;
    logic           we;
    logic [AW-1:0]  waddr;

    logic [9:0]     len_c;
    logic [XW-1:0]  total_c, fill_x, endoff_x, idx1_x, pdrop_x;
    logic           last_c;

    // circular buffer address: head plus offset, wrapped once
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] off);
        logic [XW-1:0] s;
        s = XW'(h) + XW'(off);
        if (s >= DEPTH_X)
            s = s - DEPTH_X;
        return s[AW-1:0];
    endfunction

    assign len_c    = {b1_reg, rdata_reg};
    assign total_c  = XW'(len_c) + XW'(6);
    assign fill_x   = XW'(fill_reg);
    assign endoff_x = XW'(len_reg) + XW'(3);
    assign idx1_x   = XW'(idx_reg) + XW'(1);
    assign pdrop_x  = XW'(pdrop_reg);
    assign last_c   = (pkind_reg == KIND_WAIT) || (cnt_reg == LAST_RESULT);

    assign q_pop    = (state_reg == S_POP);
    assign we       = q_pop && q_head.valid && (fill_x < DEPTH_X);
    assign waddr    = wrap(head_reg, fill_reg);

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        rdoff_next = rdoff_reg;
        len_next   = len_reg;
        b1_next    = b1_reg;
        crc_next   = crc_reg;
        rx0_next   = rx0_reg;
        rx1_next   = rx1_reg;
        cnt_next   = cnt_reg;
        pkind_next = pkind_reg;
        pflen_next = pflen_reg;
        pdrop_next = pdrop_reg;
        ov_next    = ov_reg && !out_ready;
        okind_next = okind_reg;
        oflen_next = oflen_reg;
        oid_next   = oid_reg;
        odrop_next = odrop_reg;
        olast_next = olast_reg;

        unique case (state_reg)
            S_POP:
            begin
                if (q_head.valid)
                begin
                    if (fill_x < DEPTH_X)
                        fill_next = fill_reg + CW'(1);
                    cnt_next   = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                pkind_next = KIND_WAIT;
                pflen_next = '0;
                pdrop_next = '0;
                if (fill_reg == '0)
                    state_next = S_EMIT;
                else
                begin
                    rdoff_next = '0;
                    state_next = S_B0;
                end
            end
            S_B0:
            begin
                if (rdata_reg != PREAMBLE)
                begin
                    pkind_next = KIND_DROP;
                    pdrop_next = fill_reg;
                    state_next = S_EMIT;
                end
                else if (fill_x < XW'(3))
                    state_next = S_EMIT;
                else
                begin
                    rdoff_next = CW'(1);
                    state_next = S_B1;
                end
            end
            S_B1:
            begin
                b1_next    = rdata_reg[1:0];
                rdoff_next = CW'(2);
                state_next = S_B2;
            end
            S_B2:
            begin
                len_next = len_c;
                if ((len_c > {1'b0, max_pl}) || (total_c > DEPTH_X))
                begin
                    pkind_next = KIND_DROP;
                    pdrop_next = CW'(1);
                    state_next = S_EMIT;
                end
                else if (fill_x < total_c)
                    state_next = S_EMIT;
                else
                begin
                    crc_next   = '0;
                    idx_next   = '0;
                    rdoff_next = '0;
                    state_next = S_CRC;
                end
            end
            S_CRC:
            begin
                crc_next = crc24q_step(crc_reg, rdata_reg);
                if (idx1_x < endoff_x)
                begin
                    idx_next   = idx_reg + CW'(1);
                    rdoff_next = idx_reg + CW'(1);
                end
                else
                begin
                    rdoff_next = CW'(endoff_x);
                    state_next = S_T0;
                end
            end
            S_T0:
            begin
                rx0_next   = rdata_reg;
                rdoff_next = CW'(endoff_x + XW'(1));
                state_next = S_T1;
            end
            S_T1:
            begin
                rx1_next   = rdata_reg;
                rdoff_next = CW'(endoff_x + XW'(2));
                state_next = S_T2;
            end
            S_T2:
            begin
                if ({rx0_reg, rx1_reg, rdata_reg} == crc_reg)
                begin
                    pkind_next = KIND_FRAME;
                    pflen_next = 10'(endoff_x + XW'(3));
                    pdrop_next = CW'(endoff_x + XW'(3));
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = CW'(1);
                    rdoff_next = CW'(1);
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                // next preamble after position 0, or the whole buffer
                if (rdata_reg == PREAMBLE)
                begin
                    pkind_next = KIND_DROP;
                    pdrop_next = idx_reg;
                    state_next = S_EMIT;
                end
                else if (idx1_x >= fill_x)
                begin
                    pkind_next = KIND_DROP;
                    pdrop_next = fill_reg;
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    rdoff_next = idx_reg + CW'(1);
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    okind_next = pkind_reg;
                    oflen_next = pflen_reg;
                    oid_next   = (pkind_reg == KIND_FRAME) ? {id_hi_reg, id_lo_reg[7:4]} : '0;
                    // a frame removes bytes too, but only drops report a count
                    odrop_next = (pkind_reg == KIND_DROP) ? pdrop_x[9:0] : '0;
                    olast_next = last_c;
                    if (pdrop_x >= fill_x)
                    begin
                        fill_next = '0;
                        head_next = '0;
                    end
                    else
                    begin
                        fill_next = fill_reg - pdrop_reg;
                        head_next = wrap(head_reg, pdrop_reg);
                    end
                    cnt_next   = cnt_reg + 6'd1;
                    state_next = last_c ? S_POP : S_CHECK;
                end
            end
            default:
                state_next = S_POP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_POP;
            head_reg  <= '0;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        rdoff_reg <= rdoff_next;
        len_reg   <= len_next;
        b1_reg    <= b1_next;
        crc_reg   <= crc_next;
        rx0_reg   <= rx0_next;
        rx1_reg   <= rx1_next;
        pkind_reg <= pkind_next;
        pflen_reg <= pflen_next;
        pdrop_reg <= pdrop_next;
        okind_reg <= okind_next;
        oflen_reg <= oflen_next;
        oid_reg   <= oid_next;
        odrop_reg <= odrop_next;
        olast_reg <= olast_next;
        // message id bytes caught whenever offsets 3 and 4 come by
        if (rdoff_reg == CW'(3))
            id_hi_reg <= rdata_reg;
        if (rdoff_reg == CW'(4))
            id_lo_reg <= rdata_reg;
    end

    // frame buffer, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= q_head.data;
        rdata_reg <= mem[wrap(head_reg, rdoff_next)];
    end

    assign out_valid    = ov_reg;
    assign event_kind   = okind_reg;
    assign frame_length = oflen_reg;
    assign message_id   = oid_reg;
    assign drop_count   = odrop_reg;
    assign is_last      = olast_reg;

endmodule

// ===== rtl/core/rtcm3_frame_finder_top.sv =====
// Channel  | Handshake                  | Words
// ---------+----------------------------+------------------------------------------
// in       | in_valid / in_ready        | rx_byte
// out      | out_valid / out_ready      | event_kind, frame_length, message_id,
//          |                            | drop_count, is_last
// cfg      | cfg_wr_en (no wait)        | cfg_wr_data = max_payload_length
//
// Each check runs through CHECK (empty buffer), B0 (no preamble, under 3 bytes),
// B1 and B2 (length field: wait or length drop), CRC over header and payload,
// T0 to T2 (received CRC) and EMIT, going to EMIT once the case is decided; a
// CRC mismatch scans on in SRCH to the next preamble. A byte is appended in POP.
// Reset clears queue, fill count, head and control; buffer contents stay as
// they are and are never read before being written.
// A two-word input queue accepts words while the back end checks, until full,
// and the output register holds a result while the next check is prepared.
module rtcm3_frame_finder_top #(
    parameter int BUFFER_DEPTH = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [9:0]  frame_length,
    output logic [11:0] message_id,
    output logic [9:0]  drop_count,
    output logic        is_last,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);
    import rff_pkg::*;

    q_word_t    q_head;
    logic       q_pop;
    logic [8:0] max_pl_reg;

    // payload length limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_pl_reg <= MAX_PL_RESET;
        else if (cfg_wr_en)
            max_pl_reg <= cfg_wr_data;
    end

    // front: input word queue
    rff_in_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .head     (q_head),
        .pop      (q_pop)
    );

    // back: buffer, checks and result register
    rff_engine #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .max_pl       (max_pl_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .frame_length (frame_length),
        .message_id   (message_id),
        .drop_count   (drop_count),
        .is_last      (is_last)
    );

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind != 2'd3))
        else $error("illegal event kind");

    a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KIND_WAIT) |-> is_last)
        else $error("wait result not last");

    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KIND_FRAME) |->
            (frame_length >= 10'd6 && drop_count == 10'd0))
        else $error("bad frame result");

    a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_kind == KIND_DROP) |-> (frame_length == 10'd0 && message_id == 12'd0))
        else $error("drop result carries frame fields");

endmodule

// ===== test/tb_rtcm3_frame_finder_top.sv =====
`timescale 1ns / 1ps

module tb_rtcm3_frame_finder_top;
    import rff_pkg::*;

    localparam int DEPTH      = 512;
    localparam int CYCLE_CAP  = 1000000;
    localparam int SETTLE     = 40;     // cycles after the last word before a register write
    localparam int HOLD_LEN   = 400;    // long receiver hold-off
    localparam int IDLE_PCT   = 26;

    typedef struct {
        logic [1:0]  kind;
        logic [9:0]  flen;
        logic [11:0] id;
        logic [9:0]  drop;
        logic        last;
    } frame_event_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  event_kind;
    logic [9:0]  frame_length;
    logic [11:0] message_id;
    logic [9:0]  drop_count;
    logic        is_last;
    logic        cfg_wr_en;
    logic [8:0]  cfg_wr_data;

    rtcm3_frame_finder_top #(.BUFFER_DEPTH(DEPTH)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .frame_length (frame_length),
        .message_id   (message_id),
        .drop_count   (drop_count),
        .is_last      (is_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    // stimulus bytes waiting for the driver, events waiting for the monitor
    logic [7:0]   byte_q[$];
    frame_event_t event_q[$];

    // shadow of the frame synchronizer
    logic [7:0]   shadow_buf[DEPTH];
    int           shadow_fill;
    logic [8:0]   shadow_max_pl;

    int  n_errors;
    int  n_accepted;
    int  cycles;
    bit  calm;          // no idling on either side while set
    bit  hold_done;
    int  hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [23:0] crc24q_over(int n);
        logic [23:0] crc;
        crc = '0;
        for (int i = 0; i < n; i++)
        begin
            crc = crc ^ {shadow_buf[i], 16'h0};
            for (int b = 0; b < 8; b++)
                crc = crc[23] ? ({crc[22:0], 1'b0} ^ 24'h864CFB) : {crc[22:0], 1'b0};
        end
        return crc;
    endfunction

    function automatic void shift_out(int n);
        if (n >= shadow_fill)
            shadow_fill = 0;
        else
        begin
            for (int i = 0; i < shadow_fill - n; i++)
                shadow_buf[i] = shadow_buf[i + n];
            shadow_fill = shadow_fill - n;
        end
    endfunction

    // append one word and queue every event it causes
    function automatic void sync_on_byte(logic [7:0] b);
        frame_event_t ev;
        int           count;
        bit           waiting;
        int           plen;
        int           i;
        count   = 0;
        waiting = 0;
        if (shadow_fill < DEPTH)
        begin
            shadow_buf[shadow_fill] = b;
            shadow_fill++;
        end
        while (!waiting && count < 64)
        begin
            ev = '{KIND_WAIT, 10'd0, 12'd0, 10'd0, 1'b0};
            if (shadow_fill == 0)
                waiting = 1;
            else if (shadow_buf[0] != PREAMBLE)
            begin
                // no sync: throw away everything
                ev.kind = KIND_DROP;
                ev.drop = shadow_fill[9:0];
                shift_out(shadow_fill);
            end
            else if (shadow_fill < 3)
                waiting = 1;
            else
            begin
                plen = {shadow_buf[1][1:0], shadow_buf[2]};
                if (plen > shadow_max_pl || plen + 6 > DEPTH)
                begin
                    ev.kind = KIND_DROP;
                    ev.drop = 10'd1;
                    shift_out(1);
                end
                else if (shadow_fill < plen + 6)
                    waiting = 1;
                else if ({shadow_buf[plen + 3], shadow_buf[plen + 4], shadow_buf[plen + 5]}
                         == crc24q_over(plen + 3))
                begin
                    ev.kind = KIND_FRAME;
                    ev.flen = 10'(plen + 6);
                    ev.id   = {shadow_buf[3], shadow_buf[4][7:4]};
                    shift_out(plen + 6);
                end
                else
                begin
                    // bad CRC: resync on the next preamble
                    for (i = 1; i < shadow_fill; i++)
                        if (shadow_buf[i] == PREAMBLE)
                            break;
                    ev.kind = KIND_DROP;
                    ev.drop = 10'(i);
                    shift_out(i);
                end
            end
            count++;
            ev.last = waiting || count == 64;
            event_q.push_back(ev);
        end
    endfunction

    // ---------------- stimulus builders ----------------

    // frame with payload length plen; corrupt flips a CRC bit
    task automatic push_frame(int plen, bit corrupt);
        logic [7:0]  fr[$];
        logic [23:0] crc;
        fr.push_back(PREAMBLE);
        fr.push_back({6'($urandom), 2'(plen >> 8)});   // reserved bits random
        fr.push_back(8'(plen));
        for (int i = 0; i < plen; i++)
            fr.push_back(8'($urandom));
        crc = '0;
        foreach (fr[k])
        begin
            crc = crc ^ {fr[k], 16'h0};
            for (int b = 0; b < 8; b++)
                crc = crc[23] ? ({crc[22:0], 1'b0} ^ 24'h864CFB) : {crc[22:0], 1'b0};
        end
        if (corrupt)
            crc[$urandom_range(23)] ^= 1'b1;
        fr.push_back(crc[23:16]);
        fr.push_back(crc[15:8]);
        fr.push_back(crc[7:0]);
        foreach (fr[k])
            byte_q.push_back(fr[k]);
    endtask

    task automatic wait_idle();
        while (byte_q.size() != 0 || in_valid || event_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_max_pl(logic [8:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        shadow_max_pl = v;
    endtask

    task automatic random_mix(int n_bytes, int max_len);
        int r;
        int target;
        target = byte_q.size() + n_bytes;
        while (byte_q.size() < target)
        begin
            r = $urandom_range(99);
            if (r < 60)
                push_frame($urandom_range(max_len), 1'b0);
            else if (r < 75)
                push_frame($urandom_range(max_len), 1'b1);
            else if (r < 85)
                repeat ($urandom_range(1, 5)) byte_q.push_back(8'($urandom));
            else if (r < 95)
            begin
                // header with a length above the limit
                byte_q.push_back(PREAMBLE);
                byte_q.push_back({6'($urandom), 2'b11});
                byte_q.push_back(8'($urandom));
            end
            else
            begin
                // truncated frame: header plus a little, never finished
                byte_q.push_back(PREAMBLE);
                byte_q.push_back(8'h00);
                byte_q.push_back(8'($urandom_range(4, 20)));
                repeat ($urandom_range(0, 3)) byte_q.push_back(8'($urandom));
            end
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                sync_on_byte(rx_byte);
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (byte_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= byte_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------- receiver ----------------

    // one long hold-off early on so the input queue backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= (hold_left == 1);
        end
        else if (!hold_done && n_accepted >= 30)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        frame_event_t exp_ev;
        if (rst_n && out_valid && out_ready)
        begin
            if (event_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected word: kind=%0d len=%0d id=%0d drop=%0d last=%0b",
                             event_kind, frame_length, message_id, drop_count, is_last);
            end
            else
            begin
                exp_ev = event_q.pop_front();
                if (exp_ev.kind !== event_kind || exp_ev.flen !== frame_length ||
                    exp_ev.id !== message_id || exp_ev.drop !== drop_count ||
                    exp_ev.last !== is_last)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("mismatch: exp kind=%0d len=%0d id=%0d drop=%0d last=%0b",
                                 exp_ev.kind, exp_ev.flen, exp_ev.id, exp_ev.drop,
                                 exp_ev.last);
                        $display("          got kind=%0d len=%0d id=%0d drop=%0d last=%0b",
                                 event_kind, frame_length, message_id, drop_count, is_last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_rtcm3_frame_finder_top NOT OK");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        n_errors      = 0;
        n_accepted    = 0;
        cycles        = 0;
        calm          = 1'b0;
        shadow_fill   = 0;
        shadow_max_pl = MAX_PL_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset limit
        push_frame(0, 1'b0);                         // empty payload
        push_frame(3, 1'b0);
        byte_q.push_back(8'h00);                     // junk, whole buffer dropped
        byte_q.push_back(8'hFF);
        push_frame(2, 1'b1);                         // bad CRC
        byte_q.push_back(PREAMBLE);                  // length field 1023: over limit
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'hFF);
        push_frame(1, 1'b0);
        wait_idle();

        // smallest limit: 0 passes, 1 is rejected
        write_max_pl(9'd0);
        push_frame(0, 1'b0);
        push_frame(1, 1'b0);
        push_frame(0, 1'b1);
        wait_idle();

        // largest limit: a long frame, then a header just over the limit
        write_max_pl(9'd506);
        push_frame(80, 1'b0);
        byte_q.push_back(PREAMBLE);                  // 507 is over the limit
        byte_q.push_back(8'h01);
        byte_q.push_back(8'hFB);
        push_frame(4, 1'b0);
        wait_idle();

        // random part under several limits
        write_max_pl(MAX_PL_RESET);
        random_mix(40, 16);
        wait_idle();

        write_max_pl(9'd8);
        random_mix(30, 14);
        wait_idle();

        // burst with no idling on either side
        write_max_pl(9'($urandom_range(6, 506)));
        calm = 1'b1;
        random_mix(30, 12);
        wait_idle();
        calm = 1'b0;
        random_mix(20, 12);
        wait_idle();

        if (n_errors == 0 && event_q.size() == 0)
            $display("tb_rtcm3_frame_finder_top OK");
        else
            $display("tb_rtcm3_frame_finder_top NOT OK");
        $finish;
    end

endmodule

// ===== rtcm3_frame_finder_top.f =====
rtl/core/rff_pkg.sv
rtl/core/rff_in_queue.sv
rtl/core/rff_engine.sv
rtl/core/rtcm3_frame_finder_top.sv
test/tb_rtcm3_frame_finder_top.sv
